>>> design/rrss_pkg.sv
`timescale 1ns / 1ps
package rrss_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int BURST_BITS = 12;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int CMP_W = (BURST_BITS > 8) ? BURST_BITS : 8;

    localparam int ADDR_W = 3;
    localparam logic [7:0] QUANTUM_RESET = 8'd4;
    localparam logic       REG_QUANTUM   = 1'b0;

    localparam logic [1:0] K_CLEAR   = 2'd0;
    localparam logic [1:0] K_LOAD    = 2'd1;
    localparam logic [1:0] K_ADVANCE = 2'd2;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_SLICE    = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] burst_time;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  process_id;
        logic [15:0] slice_start;
        logic [7:0]  slice_length;
        logic        finished;
        logic [15:0] waiting_time;
        logic [15:0] turnaround_time;
        logic [19:0] total_waiting;
        logic [19:0] total_turnaround;
    } result_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan_init;
        logic step;
        logic capture;
        logic slice;
        logic finish;
        logic report_done;
    } rrss_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic last;
    } rrss_stat_t;

endpackage

>>> design/rrss_ram.sv
`timescale 1ns / 1ps
module rrss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rrss_ctrl.sv
`timescale 1ns / 1ps
module rrss_ctrl
    import rrss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] kind,
    input  rrss_stat_t stat,
    output logic       busy,
    output rrss_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SLICE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        K_CLEAR:   cmd.clear = 1'b1;
                        K_LOAD:    cmd.load  = 1'b1;
                        K_ADVANCE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.report_done = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.hit)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SLICE;
                end
                else if (stat.last)
                begin
                    cmd.report_done = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_SLICE:
            begin
                cmd.slice  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a check always follows the read that fetched its entry
    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_READ))
        else $error("check state entered without a read");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

endmodule

>>> design/rrss_dp.sv
`timescale 1ns / 1ps
module rrss_dp
    import rrss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic [7:0]  quantum,
    input  rrss_cmd_t   cmd,
    output rrss_stat_t  stat,
    output logic        done,
    output result_t     result
);

    logic [CNT_W-1:0]      count_reg,    count_next;
    logic [IDX_W-1:0]      ptr_reg,      ptr_next;
    logic [15:0]           time_reg,     time_next;
    logic [19:0]           wsum_reg,     wsum_next;
    logic [19:0]           tsum_reg,     tsum_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [BURST_BITS-1:0] rem_reg,      rem_next;
    logic [BURST_BITS-1:0] burst_reg,    burst_next;
    logic [15:0]           start_reg,    start_next;
    logic [7:0]            len_reg,      len_next;
    logic                  fin_reg,      fin_next;
    logic                  done_reg,     done_next;
    result_t               result_reg,   result_next;

    logic                  full;
    logic [BURST_BITS-1:0] load_burst;
    logic [7:0]            q_eff;
    logic [7:0]            len;
    logic [BURST_BITS-1:0] new_rem;
    logic [CNT_W-1:0]      idx_plus;
    logic [15:0]           wt;
    logic [19:0]           wsum_fin;
    logic [19:0]           tsum_fin;

    logic                  ram_we_burst;
    logic                  ram_we_rem;
    logic [IDX_W-1:0]      ram_waddr;
    logic [BURST_BITS-1:0] ram_wdata_rem;
    logic [BURST_BITS-1:0] burst_rdata;
    logic [BURST_BITS-1:0] rem_rdata;

    assign full       = (count_reg >= CNT_W'(MAX_PROCS));
    assign load_burst = BURST_BITS'(item.burst_time);
    assign q_eff      = (quantum == 8'd0) ? 8'd1 : quantum;
    assign len        = (CMP_W'(rem_reg) > CMP_W'(q_eff)) ? q_eff : 8'(rem_reg);
    assign new_rem    = rem_reg - BURST_BITS'(len);
    assign idx_plus   = CNT_W'(scan_idx_reg) + CNT_W'(1);

    // time_reg already holds the finish time, which is also the turnaround
    assign wt       = time_reg - 16'(burst_reg);
    assign wsum_fin = wsum_reg + 20'(wt);
    assign tsum_fin = tsum_reg + 20'(time_reg);

    assign stat.empty = (count_reg == '0);
    assign stat.hit   = (rem_rdata != '0);
    assign stat.last  = (CNT_W'(scan_cnt_reg + CNT_W'(1)) == count_reg);

    assign ram_we_burst  = cmd.load && !full;
    assign ram_we_rem    = (cmd.load && !full) || cmd.slice;
    assign ram_waddr     = cmd.load ? IDX_W'(count_reg) : scan_idx_reg;
    assign ram_wdata_rem = cmd.load ? load_burst : new_rem;

    rrss_ram #(
        .WIDTH (BURST_BITS),
        .DEPTH (MAX_PROCS)
    ) u_burst_ram (
        .clk   (clk),
        .we    (ram_we_burst),
        .waddr (ram_waddr),
        .wdata (load_burst),
        .raddr (scan_idx_reg),
        .rdata (burst_rdata)
    );

    rrss_ram #(
        .WIDTH (BURST_BITS),
        .DEPTH (MAX_PROCS)
    ) u_rem_ram (
        .clk   (clk),
        .we    (ram_we_rem),
        .waddr (ram_waddr),
        .wdata (ram_wdata_rem),
        .raddr (scan_idx_reg),
        .rdata (rem_rdata)
    );

    always_comb
    begin
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        time_next     = time_reg;
        wsum_next     = wsum_reg;
        tsum_next     = tsum_reg;
        scan_idx_next = scan_idx_reg;
        scan_cnt_next = scan_cnt_reg;
        rem_next      = rem_reg;
        burst_next    = burst_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        fin_next      = fin_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        if (cmd.clear)
        begin
            count_next  = '0;
            ptr_next    = '0;
            time_next   = '0;
            wsum_next   = '0;
            tsum_next   = '0;
            done_next   = 1'b1;
            result_next = '0;
        end

        if (cmd.load)
        begin
            done_next   = 1'b1;
            result_next = '0;
            if (full)
            begin
                result_next.status = ST_FULL;
            end
            else
            begin
                result_next.status     = ST_ACCEPTED;
                result_next.process_id = 4'(count_reg);
                count_next             = count_reg + CNT_W'(1);
            end
        end

        if (cmd.scan_init)
        begin
            scan_idx_next = (CNT_W'(ptr_reg) < count_reg) ? ptr_reg : '0;
            scan_cnt_next = '0;
        end

        // advance the cyclic scan, wrap at the table end
        if (cmd.step)
        begin
            scan_idx_next = (idx_plus == count_reg) ? '0 : IDX_W'(idx_plus);
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
        end

        if (cmd.capture)
        begin
            rem_next   = rem_rdata;
            burst_next = burst_rdata;
        end

        if (cmd.slice)
        begin
            start_next = time_reg;
            len_next   = len;
            fin_next   = (new_rem == '0);
            time_next  = time_reg + 16'(len);
            ptr_next   = (idx_plus < count_reg) ? IDX_W'(idx_plus) : '0;
        end

        if (cmd.finish)
        begin
            done_next                = 1'b1;
            result_next              = '0;
            result_next.status       = ST_SLICE;
            result_next.process_id   = 4'(scan_idx_reg);
            result_next.slice_start  = start_reg;
            result_next.slice_length = len_reg;
            if (fin_reg)
            begin
                wsum_next                   = wsum_fin;
                tsum_next                   = tsum_fin;
                result_next.finished        = 1'b1;
                result_next.waiting_time    = wt;
                result_next.turnaround_time = time_reg;
                result_next.total_waiting   = wsum_fin;
                result_next.total_turnaround = tsum_fin;
            end
            else
            begin
                result_next.total_waiting    = wsum_reg;
                result_next.total_turnaround = tsum_reg;
            end
        end

        if (cmd.report_done)
        begin
            done_next                    = 1'b1;
            result_next                  = '0;
            result_next.status           = ST_DONE;
            result_next.total_waiting    = wsum_reg;
            result_next.total_turnaround = tsum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            time_reg     <= '0;
            wsum_reg     <= '0;
            tsum_reg     <= '0;
            scan_idx_reg <= '0;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            time_reg     <= time_next;
            wsum_reg     <= wsum_next;
            tsum_reg     <= tsum_next;
            scan_idx_reg <= scan_idx_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        burst_reg  <= burst_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
        fin_reg    <= fin_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROCS))
        else $error("process count beyond table depth");

    a_slice_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status == ST_SLICE) |-> (result_reg.slice_length != 8'd0))
        else $error("slice issued with zero length");

    a_finish_on_slice: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.finished) |-> (result_reg.status == ST_SLICE))
        else $error("finished flag on a result that is not a slice");

endmodule

>>> design/round_robin_slice_scheduler_unit.sv
`timescale 1ns / 1ps
// Round-robin slice scheduler. An item is taken when start is high and busy is
// low; its result shows on result for one cycle with done high, and the
// receiver must take it then. Clear and load items keep busy low, so they can
// be issued every cycle, each result following in the next cycle. An advance
// item keeps busy high while it searches the table, from 1 up to the process
// count entries: the search reads one entry of the remaining-work memory at a
// time through its registered read port and checks it before the next read.
// One that issues a slice then passes through a slice and a finish state. Its
// result shows in the first cycle that busy is low again. An advance on an
// empty table keeps busy low and answers in the next cycle. The quantum
// register sits at byte address 0 of the APB port.
module round_robin_slice_scheduler_unit
    import rrss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] quantum_reg;
    logic [7:0] quantum_next;
    logic       cfg_write;
    rrss_cmd_t  cmd;
    rrss_stat_t stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_QUANTUM);
    assign quantum_next = cfg_write ? pwdata[7:0] : quantum_reg;
    assign prdata    = (paddr[2] == REG_QUANTUM) ? {24'd0, quantum_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            quantum_reg <= quantum_next;
        end
    end

    rrss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    rrss_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .quantum (quantum_reg),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import rrss_pkg::*;

    localparam logic [1:0] K_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 2 * MAX_PROCS + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP = 12;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    item_t             item = '0;
    logic              done;
    result_t           result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    round_robin_slice_scheduler_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scheduler state as the block should hold it
    logic [11:0] burst_tab [MAX_PROCS];
    logic [11:0] left_tab [MAX_PROCS];
    int          proc_count = 0;
    int          next_slot = 0;
    logic [15:0] clock_now = '0;
    logic [19:0] wait_total = '0;
    logic [19:0] tat_total = '0;
    logic [7:0]  quantum_now = QUANTUM_RESET;

    result_t     pending_reports [$];
    logic [1:0]  last_status = ST_ACCEPTED;
    int          items_sent = 0;
    int          idle_pct = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic check_field(input string name, input logic [19:0] want,
                               input logic [19:0] got);
        if (want !== got)
            note_mismatch(name, 32'(want), 32'(got));
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
                note_mismatch("result with none expected, status", 32'd0,
                              32'(result.status));
            else
            begin
                want = pending_reports.pop_front();
                check_field("status", 20'(want.status), 20'(result.status));
                check_field("process_id", 20'(want.process_id),
                            20'(result.process_id));
                check_field("slice_start", 20'(want.slice_start),
                            20'(result.slice_start));
                check_field("slice_length", 20'(want.slice_length),
                            20'(result.slice_length));
                check_field("finished", 20'(want.finished), 20'(result.finished));
                check_field("waiting_time", 20'(want.waiting_time),
                            20'(result.waiting_time));
                check_field("turnaround_time", 20'(want.turnaround_time),
                            20'(result.turnaround_time));
                check_field("total_waiting", want.total_waiting, result.total_waiting);
                check_field("total_turnaround", want.total_turnaround,
                            result.total_turnaround);
            end
        end
    end

    // Work out the report for one item and update the scheduler state.
    function automatic bit predict_report(input item_t it, output result_t r);
        int          k;
        int          j;
        int          idx;
        int          first;
        bit          found;
        logic [7:0]  q;
        logic [7:0]  len;
        logic [15:0] wt;
        logic [15:0] tat;
        r = '0;
        idx = 0;
        found = 1'b0;
        case (it.kind)
            K_CLEAR:
            begin
                proc_count = 0;
                next_slot = 0;
                clock_now = '0;
                wait_total = '0;
                tat_total = '0;
                r.status = ST_ACCEPTED;
                return 1'b1;
            end
            K_LOAD:
            begin
                if (proc_count >= MAX_PROCS)
                    r.status = ST_FULL;
                else
                begin
                    burst_tab[proc_count] = it.burst_time;
                    left_tab[proc_count] = it.burst_time;
                    r.status = ST_ACCEPTED;
                    r.process_id = proc_count[3:0];
                    proc_count++;
                end
                return 1'b1;
            end
            K_ADVANCE:
            begin
                first = (next_slot < proc_count) ? next_slot : 0;
                for (k = 0; k < proc_count && !found; k++)
                begin
                    j = first + k;
                    if (j >= proc_count)
                        j -= proc_count;
                    if (left_tab[j] != '0)
                    begin
                        idx = j;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    r.status = ST_DONE;
                    r.total_waiting = wait_total;
                    r.total_turnaround = tat_total;
                    return 1'b1;
                end
                q = (quantum_now == 8'd0) ? 8'd1 : quantum_now;
                len = (left_tab[idx] > 12'(q)) ? q : left_tab[idx][7:0];
                r.status = ST_SLICE;
                r.process_id = idx[3:0];
                r.slice_start = clock_now;
                r.slice_length = len;
                clock_now = clock_now + 16'(len);
                left_tab[idx] = left_tab[idx] - 12'(len);
                next_slot = (idx + 1 < proc_count) ? idx + 1 : 0;
                if (left_tab[idx] == '0)
                begin
                    wt = clock_now - 16'(burst_tab[idx]);
                    tat = 16'(burst_tab[idx]) + wt;
                    wait_total = wait_total + 20'(wt);
                    tat_total = tat_total + 20'(tat);
                    r.finished = 1'b1;
                    r.waiting_time = wt;
                    r.turnaround_time = tat;
                end
                r.total_waiting = wait_total;
                r.total_turnaround = tat_total;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Present one item, wait for the handshake, then idle at random.
    task automatic issue_command(input logic [1:0] kind, input logic [11:0] burst);
        item_t   it;
        result_t want;
        int      gap;
        it.kind = kind;
        it.burst_time = burst;
        item <= it;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        if (predict_report(it, want))
        begin
            pending_reports.push_back(want);
            last_status = want.status;
            items_sent++;
        end
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, MAX_GAP);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {REG_QUANTUM, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Change the quantum only once the block has gone quiet.
    task automatic set_quantum(input logic [7:0] value);
        logic [31:0] rd;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_access(1'b1, {24'd0, value}, rd);
        quantum_now = value;
        apb_access(1'b0, 32'd0, rd);
        if (rd[7:0] !== value)
            note_mismatch("quantum readback", 32'(value), 32'(rd[7:0]));
    endtask

    function automatic logic [11:0] pick_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 12'd0;
        else if (r < 88)
            return 12'($urandom_range(1, 24));
        else
            return 12'($urandom_range(0, 4095));
    endfunction

    task automatic test_directed_basics();
        logic [31:0] rd;
        idle_pct = 0;
        apb_access(1'b0, 32'd0, rd);
        if (rd[7:0] !== QUANTUM_RESET)
            note_mismatch("quantum after reset", 32'(QUANTUM_RESET), 32'(rd[7:0]));
        issue_command(K_ADVANCE, 12'd0);        // empty table reports all done
        issue_command(K_LOAD, 12'd0);           // zero burst, never scheduled
        issue_command(K_LOAD, 12'hFFF);
        issue_command(K_LOAD, 12'd1);
        issue_command(K_LOAD, 12'd6);
        issue_command(K_UNUSED, 12'hAAA);
        repeat (5) issue_command(K_ADVANCE, 12'hFFF);
        issue_command(K_LOAD, 12'd3);           // joins the running cycle
        repeat (4) issue_command(K_ADVANCE, 12'd0);
        issue_command(K_UNUSED, 12'h555);
        issue_command(K_CLEAR, 12'hFFF);
        issue_command(K_ADVANCE, 12'd0);
        issue_command(K_LOAD, 12'd0);
        issue_command(K_ADVANCE, 12'd0);        // only zero bursts left
        issue_command(K_LOAD, 12'd2);
        repeat (2) issue_command(K_ADVANCE, 12'd0);
    endtask

    task automatic test_zero_quantum();
        set_quantum(8'd0);
        idle_pct = 74;
        issue_command(K_CLEAR, 12'd0);
        issue_command(K_LOAD, 12'd3);
        issue_command(K_LOAD, 12'd0);
        issue_command(K_LOAD, 12'd2);
        do issue_command(K_ADVANCE, 12'd0); while (last_status != ST_DONE);
    endtask

    // Fill the table with the longest bursts, overflow it and run it to the end.
    task automatic test_full_table_long_bursts();
        set_quantum(8'd255);
        idle_pct = 34;
        issue_command(K_CLEAR, 12'd0);
        repeat (MAX_PROCS + 2) issue_command(K_LOAD, 12'hFFF);
        do issue_command(K_ADVANCE, 12'($urandom)); while (last_status != ST_DONE);
        issue_command(K_ADVANCE, 12'd0);
    endtask

    task automatic test_random_traffic(input logic [7:0] q, input int pct,
                                       input int target);
        int stop_at;
        int cap;
        int n;
        int r;
        set_quantum(q);
        idle_pct = pct;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                if ($urandom_range(0, 3) != 0)
                    issue_command(K_CLEAR, 12'($urandom));
                repeat ($urandom_range(1, MAX_PROCS + 2))
                    issue_command(K_LOAD, pick_burst());
                cap = $urandom_range(10, 60);
                n = 0;
                do
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        issue_command(K_LOAD, pick_burst());
                    else if (r == 1)
                        issue_command(K_UNUSED, 12'($urandom));
                    issue_command(K_ADVANCE, 12'($urandom));
                    n++;
                end
                while (last_status != ST_DONE && n < cap);
            end
            else
                issue_command(2'($urandom), 12'($urandom));
            // now and then, hold off until the block has answered everything
            if ($urandom_range(0, 9) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_zero_quantum();
        test_full_table_long_bursts();
        test_random_traffic(8'd1, 0, 170);
        test_random_traffic(8'($urandom_range(2, 9)), 74, 170);
        test_random_traffic(8'd255, 34, 170);
        test_random_traffic(8'($urandom_range(10, 40)), 0, 150);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
